// ===== design/alf_pkg.sv =====
// Shared constants, preset table and types for the lagged Fibonacci generator
`timescale 1ns / 1ps

package alf_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned VALUE_W      = 31;
  localparam int unsigned PRESET_COUNT = 31;

  localparam logic [WORD_W-1:0] LCG_MUL = 32'd1664525;
  localparam logic [WORD_W-1:0] LCG_ADD = 32'd1013904223;

  // reset contents of the ring, word 0 first
  localparam logic [WORD_W-1:0] PRESET_WORDS [PRESET_COUNT] = '{
    32'h00000001, 32'h3c88596c, 32'h5e8885db,
    32'h8116017e, 32'hb4733ac5, 32'h0cf06d60, 32'h5e98c13f,
    32'hc656dd92, 32'h8e625fc9, 32'h0438e694, 32'ha3a5a0e3,
    32'h401d90e6, 32'h6c20f30d, 32'h97377908, 32'hd64148c7,
    32'h3c2def7a, 32'hfb18b891, 32'hdc6318bc, 32'h53ae1ceb,
    32'haebf0d4e, 32'h880db455, 32'h3747f9b0, 32'h1ac2c14f,
    32'h120f3e62, 32'h51a22a59, 32'h213b8fe4, 32'hb50e19f3,
    32'h953816b6, 32'h611a9e9d, 32'h43508f58, 32'hc03b4ad7
  };

  // per-cell control from the sequencer
  typedef struct packed {
    logic shift;
    logic load;
  } alf_cell_ctl_t;

  // reset word for a ring position, zero past the preset table
  function automatic logic [WORD_W-1:0] preset_word(input int idx);
    logic [WORD_W-1:0] word;
    word = '0;
    if (idx >= 0 && idx < int'(PRESET_COUNT)) begin
      word = PRESET_WORDS[idx[4:0]];
    end
    return word;
  endfunction

endpackage

// ===== design/additive_lagged_fibonacci_rng.sv =====
// Top level: ring of cells rotating under a small sequencer, with registered output
// Draw: one transfer per cycle while in_stall_o is low, result in the output register in the cycle after accept.
// Seed in ring mode: input stalls while the LCG fills the ring one word per cycle
// through the tail cell. After lcg_only changes, input stalls while the ring
// rotates one word per cycle to realign.
// Reset: ring holds the preset table, lead/lag at LEAD_START mod RING_DEPTH and 0.
`timescale 1ns / 1ps

module additive_lagged_fibonacci_rng #(
  parameter int unsigned RING_DEPTH = 31,
  parameter int unsigned LEAD_START = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         mode_i,
  input  logic [alf_pkg::WORD_W-1:0]   seed_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [alf_pkg::VALUE_W-1:0]  value_o
);

  localparam int unsigned PTR_W    = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W    = $clog2(RING_DEPTH + 1);
  localparam int unsigned LEAD_POS = LEAD_START % RING_DEPTH;
  // cell that receives the sum when the ring rotates on a draw
  localparam int unsigned SUM_POS  = (LEAD_POS + RING_DEPTH - 1) % RING_DEPTH;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  logic [alf_pkg::WORD_W-1:0] cell_word [RING_DEPTH];
  logic [alf_pkg::WORD_W-1:0] shift_word [RING_DEPTH];
  alf_pkg::alf_cell_ctl_t     cell_ctl [RING_DEPTH];

  logic                       lcg_only_q;
  logic [PTR_W-1:0]           lag_q, lag_d;
  logic [PTR_W-1:0]           rot_q, rot_d;
  logic [CNT_W-1:0]           sweep_cnt_q, sweep_cnt_d;
  logic [alf_pkg::WORD_W-1:0] x_q, x_d;
  logic                       out_valid_q, out_valid_d;
  logic [alf_pkg::VALUE_W-1:0] value_q, value_d;

  logic in_acc, draw_fib, draw_lcg, seed_fib, seed_lcg;
  logic sweeping, misaligned, rotate;
  logic [PTR_W-1:0]           align_tgt, rot_inc, lag_inc;
  logic [alf_pkg::WORD_W-1:0] sum_word, lcg_in, lcg_out;

  // transfer decode
  assign sweeping   = (sweep_cnt_q != '0);
  assign align_tgt  = lcg_only_q ? '0 : lag_q;
  assign misaligned = (rot_q != align_tgt);
  assign in_stall_o = sweeping | misaligned | (out_valid_q & out_stall_i);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign draw_fib   = in_acc & ~mode_i & ~lcg_only_q;
  assign draw_lcg   = in_acc & ~mode_i &  lcg_only_q;
  assign seed_fib   = in_acc &  mode_i & ~lcg_only_q;
  assign seed_lcg   = in_acc &  mode_i &  lcg_only_q;
  assign rotate     = draw_fib | sweeping | misaligned;

  // lag word sits in cell 0, lead word at a fixed offset
  assign sum_word = cell_word[0] + cell_word[LEAD_POS];

  // shared LCG step: fill sweep or single-word draw
  assign lcg_in = sweeping ? x_q : cell_word[0];

  alf_lcg_step u_lcg (
    .x_i (lcg_in),
    .x_o (lcg_out)
  );

  // neighbor words and per-cell control
  always_comb begin
    // each cell takes its right neighbor, the tail wraps around to cell 0
    for (int i = 0; i < int'(RING_DEPTH) - 1; i++) begin
      shift_word[i] = cell_word[i + 1];
    end
    shift_word[RING_DEPTH-1] = cell_word[0];
    if (draw_fib) begin
      shift_word[SUM_POS] = sum_word;
    end else if (sweeping) begin
      shift_word[RING_DEPTH-1] = x_q;
    end
    for (int i = 0; i < int'(RING_DEPTH); i++) begin
      cell_ctl[i].shift = rotate;
      cell_ctl[i].load  = (i == 0) ? (draw_lcg | seed_lcg) : 1'b0;
    end
  end

  // ring of cells
  for (genvar g = 0; g < int'(RING_DEPTH); g++) begin : g_cell
    alf_cell #(
      .RESET_WORD (alf_pkg::preset_word(g))
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (cell_ctl[g]),
      .shift_word_i (shift_word[g]),
      .load_word_i  (seed_lcg ? seed_i : lcg_out),
      .word_o       (cell_word[g])
    );
  end

  // pointer and sweep bookkeeping
  assign rot_inc = (rot_q == PTR_LAST) ? '0 : rot_q + 1'b1;
  assign lag_inc = (lag_q == PTR_LAST) ? '0 : lag_q + 1'b1;

  always_comb begin
    rot_d       = rot_q;
    lag_d       = lag_q;
    sweep_cnt_d = sweep_cnt_q;
    x_d         = x_q;
    if (seed_fib) begin
      rot_d       = '0;
      lag_d       = '0;
      sweep_cnt_d = CNT_W'(RING_DEPTH);
      x_d         = seed_i;
    end else if (seed_lcg) begin
      lag_d = '0;
    end else if (draw_fib) begin
      rot_d = rot_inc;
      lag_d = lag_inc;
    end else if (sweeping) begin
      sweep_cnt_d = sweep_cnt_q - 1'b1;
      x_d         = lcg_out;
    end else if (misaligned) begin
      rot_d = rot_inc;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    value_d     = value_q;
    if (in_acc && !mode_i) begin
      out_valid_d = 1'b1;
      value_d     = draw_fib ? sum_word[alf_pkg::WORD_W-1:1] : lcg_out[alf_pkg::WORD_W-1:1];
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_only_q  <= 1'b0;
      rot_q       <= '0;
      lag_q       <= '0;
      sweep_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lcg_only_q <= cfg_wdata_i;
      end
      rot_q       <= rot_d;
      lag_q       <= lag_d;
      sweep_cnt_q <= sweep_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    value_q <= value_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  // checks
  a_fib_draw_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw_fib |-> (rot_q == lag_q))
    else $error("ring draw taken with ring not aligned to lag pointer");

  a_lcg_draw_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (draw_lcg || seed_lcg) |-> (rot_q == '0))
    else $error("single-word transfer taken with word 0 not in cell 0");

  a_seed_starts_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_fib |=> (sweeping && in_stall_o && rot_q == '0 && lag_q == '0))
    else $error("ring seed did not start the fill sweep");

  a_sweep_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sweeping && !out_valid_q) |=> !out_valid_q)
    else $error("result appeared during the fill sweep");

endmodule

// ===== design/alf_lcg_step.sv =====
// One step of the linear congruential generator, x*a + c modulo 2^32
`timescale 1ns / 1ps

module alf_lcg_step (
  input  logic [alf_pkg::WORD_W-1:0] x_i,
  output logic [alf_pkg::WORD_W-1:0] x_o
);

  logic [alf_pkg::WORD_W-1:0] prod;

  // low half of the product is all that matters modulo 2^32
  assign prod = x_i * alf_pkg::LCG_MUL;
  assign x_o  = prod + alf_pkg::LCG_ADD;

endmodule

// ===== design/alf_cell.sv =====
// One ring cell: holds a word, loads a new one or takes its neighbor's word
`timescale 1ns / 1ps

module alf_cell #(
  parameter logic [31:0] RESET_WORD = 32'h0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  alf_pkg::alf_cell_ctl_t      ctl_i,
  input  logic [alf_pkg::WORD_W-1:0]  shift_word_i,
  input  logic [alf_pkg::WORD_W-1:0]  load_word_i,
  output logic [alf_pkg::WORD_W-1:0]  word_o
);

  logic [alf_pkg::WORD_W-1:0] word_q, word_d;

  // load wins over the shift
  always_comb begin
    word_d = word_q;
    if (ctl_i.load) begin
      word_d = load_word_i;
    end else if (ctl_i.shift) begin
      word_d = shift_word_i;
    end
  end

  // ring state comes out of reset with its preset word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= RESET_WORD;
    end else begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule
